### sv/mia_pkg.sv
`default_nettype none
package mia_pkg;

  typedef enum logic [4:0] {
    K_MULT, K_MULTU, K_DIV, K_DIVU, K_ADD, K_ADDU, K_SUB, K_SUBU,
    K_DADD, K_DADDU, K_DSUB, K_DSUBU, K_SRAV, K_XOR, K_SLT, K_SLL,
    K_SRL, K_SRA, K_SLLV, K_SRLV
  } kind_e;

  localparam int unsigned NumCells = 32;

  typedef struct packed {
    logic [4:0]  kind;
    logic [63:0] operand_a;
    logic [63:0] operand_b;
    logic [4:0]  shift_amount;
  } in_t;

  typedef struct packed {
    logic [63:0] dest_value;
    logic        dest_write;
    logic [63:0] lo_value;
    logic [63:0] hi_value;
    logic        lohi_write;
  } out_t;

  // Word in flight along the divider row. For divides, rem and quo hold the
  // partial remainder and the dividend that shifts into the quotient; for all
  // other kinds wide carries the finished value or the raw product.
  typedef struct packed {
    logic        valid;
    kind_e       kind;
    logic        neg;
    logic        neg_r;
    logic        dz;
    logic [31:0] a_raw;
    logic [31:0] rem;
    logic [31:0] quo;
    logic [31:0] dvsr;
    logic [63:0] wide;
  } tok_t;

  function automatic logic [63:0] sext32(input logic [31:0] w);
    return {{32{w[31]}}, w};
  endfunction

endpackage
`default_nettype wire

### sv/mia_front.sv
`default_nettype none
module mia_front (
  input  mia_pkg::in_t  item_i,
  input  logic          start_i,
  output mia_pkg::tok_t tok_o
);
  import mia_pkg::*;

  logic [31:0] a32, b32, mag_a, mag_b;
  logic [4:0]  va, sa;
  logic [31:0] sum32, dif32, sraa, srav;
  kind_e       kind;

  assign kind  = kind_e'(item_i.kind);
  assign a32   = item_i.operand_a[31:0];
  assign b32   = item_i.operand_b[31:0];
  assign va    = a32[4:0];
  assign sa    = item_i.shift_amount;
  assign mag_a = a32[31] ? 32'(-a32) : a32;
  assign mag_b = b32[31] ? 32'(-b32) : b32;
  assign sum32 = a32 + b32;
  assign dif32 = a32 - b32;
  assign sraa  = 32'($signed(b32) >>> sa);
  assign srav  = 32'($signed(b32) >>> va);

  always_comb begin
    tok_o       = '0;
    tok_o.valid = start_i;
    tok_o.kind  = kind;
    tok_o.a_raw = a32;
    case (kind)
      K_MULT: begin
        tok_o.neg  = a32[31] ^ b32[31];
        tok_o.wide = 64'(mag_a) * 64'(mag_b);
      end
      K_MULTU: tok_o.wide = 64'(a32) * 64'(b32);
      K_DIV: begin
        tok_o.neg   = a32[31] ^ b32[31];
        tok_o.neg_r = a32[31];
        tok_o.dz    = (b32 == '0);
        tok_o.quo   = mag_a;
        tok_o.dvsr  = mag_b;
      end
      K_DIVU: begin
        tok_o.dz   = (b32 == '0);
        tok_o.quo  = a32;
        tok_o.dvsr = b32;
      end
      K_ADD, K_ADDU:   tok_o.wide = sext32(sum32);
      K_SUB, K_SUBU:   tok_o.wide = sext32(dif32);
      K_DADD, K_DADDU: tok_o.wide = item_i.operand_a + item_i.operand_b;
      K_DSUB, K_DSUBU: tok_o.wide = item_i.operand_a - item_i.operand_b;
      K_SRAV: tok_o.wide = sext32(srav);
      K_XOR:  tok_o.wide = item_i.operand_a ^ item_i.operand_b;
      K_SLT:  tok_o.wide = {63'd0, $signed(item_i.operand_a) < $signed(item_i.operand_b)};
      K_SLL:  tok_o.wide = sext32(b32 << sa);
      K_SRL:  tok_o.wide = sext32(b32 >> sa);
      K_SRA:  tok_o.wide = sext32(sraa);
      K_SLLV: tok_o.wide = sext32(b32 << va);
      K_SRLV: tok_o.wide = sext32(b32 >> va);
      default: tok_o.wide = '0;
    endcase
  end
endmodule
`default_nettype wire

### sv/mia_cell.sv
`default_nettype none
module mia_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  mia_pkg::tok_t tok_i,
  output mia_pkg::tok_t tok_o
);
  import mia_pkg::*;

  tok_t        tok_d, tok_q;
  logic [32:0] trial;

  // One restoring division step: one quotient bit per cell.
  always_comb begin
    tok_d = tok_i;
    trial = {tok_i.rem, tok_i.quo[31]} - {1'b0, tok_i.dvsr};
    if (!trial[32]) begin
      tok_d.rem = trial[31:0];
      tok_d.quo = {tok_i.quo[30:0], 1'b1};
    end else begin
      tok_d.rem = {tok_i.rem[30:0], tok_i.quo[31]};
      tok_d.quo = {tok_i.quo[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;
endmodule
`default_nettype wire

### sv/mia_back.sv
`default_nettype none
module mia_back (
  input  mia_pkg::tok_t tok_i,
  output mia_pkg::out_t res_o
);
  import mia_pkg::*;

  logic [63:0] prod;
  logic [31:0] q, r;

  assign prod = tok_i.neg ? 64'(-tok_i.wide) : tok_i.wide;
  assign q    = tok_i.neg ? 32'(-tok_i.quo) : tok_i.quo;
  assign r    = tok_i.neg_r ? 32'(-tok_i.rem) : tok_i.rem;

  always_comb begin
    res_o = '0;
    case (tok_i.kind)
      K_MULT, K_MULTU: begin
        res_o.lo_value   = sext32(prod[31:0]);
        res_o.hi_value   = sext32(prod[63:32]);
        res_o.dest_value = sext32(prod[31:0]);
        res_o.dest_write = 1'b1;
        res_o.lohi_write = 1'b1;
      end
      K_DIV, K_DIVU: begin
        res_o.lohi_write = 1'b1;
        if (tok_i.dz) begin
          // Divide by zero: a negative signed dividend gives a quotient of one.
          res_o.lo_value = (tok_i.kind == K_DIV && tok_i.a_raw[31]) ? 64'd1 : '1;
          res_o.hi_value = sext32(tok_i.a_raw);
        end else begin
          res_o.lo_value = sext32(q);
          res_o.hi_value = sext32(r);
        end
      end
      K_ADD, K_ADDU, K_SUB, K_SUBU, K_DADD, K_DADDU, K_DSUB, K_DSUBU,
      K_SRAV, K_XOR, K_SLT, K_SLL, K_SRL, K_SRA, K_SLLV, K_SRLV: begin
        res_o.dest_value = tok_i.wide;
        res_o.dest_write = 1'b1;
      end
      default: res_o = '0;
    endcase
  end
endmodule
`default_nettype wire

### sv/mips64_integer_alu.sv
`default_nettype none
// MIPS64 integer ALU with 32-bit multiply and divide.
// Input channel: an operation word on item_i is taken at each rising edge
// where start_i is high and busy_o is low. busy_o is always low, so a new
// word may be issued in every cycle.
// Output channel: each accepted word yields exactly one result word on
// result_o, shown for one cycle while result_valid_o is high. The receiver
// cannot stall; results leave in issue order.
// Every operation takes the same path: one register after operand decode and
// the multiplier, 32 divider cells that each resolve one quotient
// bit, and the output register. Throughput is one word per cycle; the cell
// row is fully pipelined, so multiplies and divides overlap freely with
// everything else.
// Reset clears all valid flags; words in flight are dropped and no result
// strobe appears until a new word is issued.
module mips64_integer_alu (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  mia_pkg::in_t  item_i,
  output logic          result_valid_o,
  output mia_pkg::out_t result_o
);
  import mia_pkg::*;

  tok_t front_tok, tok_q;
  tok_t chain [0:NumCells];
  out_t res_d, res_q;
  logic valid_q;

  assign busy_o = 1'b0;

  // Decode, the simple ALU operations and the 32x32 multiply happen here.
  mia_front u_front (
    .item_i  (item_i),
    .start_i (start_i),
    .tok_o   (front_tok)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= front_tok;
    end
  end

  assign chain[0] = tok_q;

  // The divider row: each cell holds one word and passes it on every cycle.
  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    mia_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .tok_i  (chain[i]),
      .tok_o  (chain[i+1])
    );
  end

  // Sign fix-up of product, quotient and remainder, and the divide-by-zero rules.
  mia_back u_back (
    .tok_i (chain[NumCells]),
    .res_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      res_q   <= '0;
    end else begin
      valid_q <= chain[NumCells].valid;
      res_q   <= res_d;
    end
  end

  assign result_valid_o = valid_q;
  assign result_o       = res_q;

  a_dest_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.dest_write |-> result_o.dest_value == '0)
    else $error("dest_value nonzero without a write");
  a_lohi_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.lohi_write |->
      result_o.lo_value == '0 && result_o.hi_value == '0)
    else $error("LO/HI nonzero without a write");
  a_mult_dest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.dest_write && result_o.lohi_write |->
      result_o.dest_value == result_o.lo_value)
    else $error("multiply destination differs from LO");
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain[NumCells].valid |=> result_valid_o)
    else $error("word lost at the output register");
endmodule
`default_nettype wire
